@@ hdl/skyline_interval_placement_defines.svh @@
// Assertion macros shared by the skyline placement RTL
`ifndef SKYLINE_INTERVAL_PLACEMENT_DEFINES_SVH
`define SKYLINE_INTERVAL_PLACEMENT_DEFINES_SVH

// Same-cycle implication, sampled on clk, held off during reset
`define SIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset
`define SIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sip_pkg.sv @@
// Shared types, constants and helpers for the skyline placement block
package sip_pkg;

    localparam int COLUMNS = 64;
    localparam int COL_W   = 7;
    localparam int H_W     = 24;
    localparam int SIZE_W  = 20;
    localparam int ID_W    = 16;
    localparam int MASK_W  = 64;
    localparam int CNT_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [H_W-1:0] HMAX = {H_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARRY_IN     = 2'd2;

    typedef logic [COL_W-1:0] col_t;
    typedef logic [H_W-1:0]   height_t;

    // Packet that ripples down the cell chain during a scan
    typedef struct packed {
        height_t run_max;
        height_t bot_lo;
        height_t top_hi;
        height_t span_hi;
    } scan_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic    fin;
        logic    place_en;
        logic    clear_en;
        col_t    lo;
        col_t    hi;
        col_t    bl;
        col_t    br;
        height_t carry;
        height_t level;
        height_t newtop;
    } cell_ctrl_t;

    // Saturating add of two heights
    function automatic height_t sat_add(input height_t a, input height_t b);
        logic [H_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[H_W] ? HMAX : s[H_W-1:0];
        end
    endfunction

endpackage

@@ hdl/sip_cell.sv @@
// One column cell: holds top, bottom and touched flag, forwards the scan packet
module sip_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  sip_pkg::col_t      idx,
    input  sip_pkg::cell_ctrl_t ctrl,
    input  sip_pkg::scan_t     scan_in,
    output sip_pkg::scan_t     scan_out,
    output logic               mask_bit,
    output logic               touched
);
    import sip_pkg::*;

    height_t top_reg, top_next;
    height_t bottom_reg, bottom_next;
    logic    touched_reg, touched_next;
    scan_t   scan_reg, scan_next;

    logic    in_win, in_blk, at_lo, at_hi;
    height_t span, eff_span, contrib;

    // Column position against window and block
    always_comb
    begin
        in_win = (idx >= ctrl.lo) && (idx <= ctrl.hi);
        in_blk = in_win && (idx >= ctrl.bl) && (idx <= ctrl.br);
        at_lo  = in_win && (idx == ctrl.lo);
        at_hi  = in_win && (idx == ctrl.hi);
    end

    // Span of this column, carry added at the left window edge
    always_comb
    begin
        span     = (touched_reg && (top_reg >= bottom_reg)) ? (top_reg - bottom_reg) : '0;
        eff_span = at_lo ? sat_add(span, ctrl.carry) : span;
        if (ctrl.fin)
            contrib = (in_win && touched_reg) ? eff_span : '0;
        else
            contrib = in_blk ? top_reg : '0;
    end

    // Scan packet for the next cell
    always_comb
    begin
        scan_next         = scan_in;
        scan_next.run_max = (contrib > scan_in.run_max) ? contrib : scan_in.run_max;
        if (at_lo)
            scan_next.bot_lo = bottom_reg;
        if (at_hi)
        begin
            scan_next.top_hi  = top_reg;
            scan_next.span_hi = span;
        end
    end

    // Column update on place, clear on finish
    always_comb
    begin
        priority if (ctrl.clear_en)
        begin
            top_next     = '0;
            bottom_next  = HMAX;
            touched_next = 1'b0;
        end
        else if (ctrl.place_en && in_blk)
        begin
            top_next     = ctrl.newtop;
            bottom_next  = (ctrl.level < bottom_reg) ? ctrl.level : bottom_reg;
            touched_next = 1'b1;
        end
        else
        begin
            top_next     = top_reg;
            bottom_next  = bottom_reg;
            touched_next = touched_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg     <= '0;
            bottom_reg  <= HMAX;
            touched_reg <= 1'b0;
        end
        else
        begin
            top_reg     <= top_next;
            bottom_reg  <= bottom_next;
            touched_reg <= touched_next;
        end
    end

    // Chain stage register
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    assign scan_out = scan_reg;
    assign mask_bit = ctrl.fin && in_win && touched_reg && (eff_span == ctrl.level);
    assign touched  = touched_reg;

endmodule

@@ hdl/skyline_interval_placement.sv @@
// Skyline interval placement: controller and chain of column cells
//
// Input channel (in_valid / in_stall): action 0 places a block over
// block_left..block_right (inside the window) and returns its offset with placed_id; action 1
// returns the summary (peak span, edge values, bottleneck mask) and clears
// every column. Each accepted item gives exactly one result.
// Output channel (out_valid / out_stall): a result sits in an output
// register until transferred; out_valid does not look at out_stall.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
// always high; index 0 window_left, 1 window_right, 2 carry_in, 3 ignored.
// Write configuration only while no item is in flight.
// Timing: the range maximum ripples through the column cells one cell per
// cycle; an item passes through ST_SCAN and ST_APPLY before out_valid rises,
// and the next item is accepted only once the block is back in ST_IDLE, so
// items do not overlap. The next item is accepted while the previous
// result still waits in the output register; if that result is still
// stalled when the next one is ready, the block holds it in ST_APPLY until
// the register frees.
// Reset: all columns return to their empty state at once (no sweep); the
// controller registers are reset, the chain stage registers are not.
`include "skyline_interval_placement_defines.svh"

module skyline_interval_placement (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [sip_pkg::COL_W-1:0]         block_left,
    input  logic [sip_pkg::COL_W-1:0]         block_right,
    input  logic [sip_pkg::SIZE_W-1:0]        block_size,
    input  logic [sip_pkg::ID_W-1:0]          block_id,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              is_summary,
    output logic [sip_pkg::H_W-1:0]           placement_offset,
    output logic [sip_pkg::ID_W-1:0]          placed_id,
    output logic [sip_pkg::H_W-1:0]           peak_span,
    output logic [sip_pkg::H_W-1:0]           bottom_at_left,
    output logic [sip_pkg::H_W-1:0]           top_at_right,
    output logic [sip_pkg::H_W-1:0]           span_at_right,
    output logic [sip_pkg::MASK_W-1:0]        bottleneck_mask,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sip_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sip_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sip_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    cnt_reg;

    // Configuration registers
    col_t                wl_reg, wr_reg;
    height_t             carry_reg;

    // Item in flight
    logic                fin_reg;
    col_t                bl_reg, br_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [ID_W-1:0]     id_reg;

    // Output register
    logic                out_valid_reg;
    logic                is_summary_reg;
    height_t             offset_reg, peak_reg, bot_lo_reg, top_hi_reg, span_hi_reg;
    logic [ID_W-1:0]     pid_reg;
    logic [MASK_W-1:0]   mask_reg;

    col_t                lo, hi;
    scan_t               chain [0:COLUMNS];
    cell_ctrl_t          ctrl;
    logic [COLUMNS-1:0]  mask_vec, touched_vec;
    height_t             level, newtop;
    logic                in_fire, out_fire, apply_fire;

    // Effective window limited to the column range
    assign lo = (wl_reg == '0) ? col_t'(1) : wl_reg;
    assign hi = (wr_reg > col_t'(COLUMNS)) ? col_t'(COLUMNS) : wr_reg;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign out_fire   = out_valid_reg && !out_stall;
    assign apply_fire = (state_reg == ST_APPLY) && (!out_valid_reg || !out_stall);
    assign cfg_ready  = 1'b1;

    // End of the chain: range maximum or peak span
    assign level  = chain[COLUMNS].run_max;
    assign newtop = sat_add(level, H_W'(size_reg));

    // Scan seed
    assign chain[0] = '{run_max: '0, bot_lo: HMAX, top_hi: '0, span_hi: '0};

    // Broadcast to the cells
    always_comb
    begin
        ctrl.fin      = fin_reg;
        ctrl.place_en = apply_fire && !fin_reg;
        ctrl.clear_en = apply_fire && fin_reg;
        ctrl.lo       = lo;
        ctrl.hi       = hi;
        ctrl.bl       = bl_reg;
        ctrl.br       = br_reg;
        ctrl.carry    = carry_reg;
        ctrl.level    = level;
        ctrl.newtop   = newtop;
    end

    // Column cells, numbered from 1
    for (genvar i = 0; i < COLUMNS; i++)
    begin : g_cell
        sip_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (col_t'(i + 1)),
            .ctrl     (ctrl),
            .scan_in  (chain[i]),
            .scan_out (chain[i+1]),
            .mask_bit (mask_vec[i]),
            .touched  (touched_vec[i])
        );
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg    <= col_t'(1);
            wr_reg    <= col_t'(64);
            carry_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WINDOW_LEFT:  wl_reg    <= cfg_data[COL_W-1:0];
                REG_WINDOW_RIGHT: wr_reg    <= cfg_data[COL_W-1:0];
                REG_CARRY_IN:     carry_reg <= cfg_data[H_W-1:0];
                default:          ;
            endcase
        end
    end

    // Sequencer, item capture and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            fin_reg        <= 1'b0;
            bl_reg         <= '0;
            br_reg         <= '0;
            size_reg       <= '0;
            id_reg         <= '0;
            out_valid_reg  <= 1'b0;
            is_summary_reg <= 1'b0;
            offset_reg     <= '0;
            pid_reg        <= '0;
            peak_reg       <= '0;
            bot_lo_reg     <= '0;
            top_hi_reg     <= '0;
            span_hi_reg    <= '0;
            mask_reg       <= '0;
        end
        else
        begin
            // a new result reloads the register in the cycle the old one leaves
            if (out_fire && !apply_fire)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        fin_reg   <= action;
                        bl_reg    <= block_left;
                        br_reg    <= block_right;
                        size_reg  <= block_size;
                        id_reg    <= block_id;
                        cnt_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // wait while the wave passes through every cell register to the chain end
                    if (cnt_reg == CNT_W'(COLUMNS - 1))
                        state_reg <= ST_APPLY;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                ST_APPLY:
                begin
                    if (apply_fire)
                    begin
                        out_valid_reg  <= 1'b1;
                        is_summary_reg <= fin_reg;
                        offset_reg     <= fin_reg ? '0 : level;
                        pid_reg        <= fin_reg ? '0 : id_reg;
                        peak_reg       <= fin_reg ? level : '0;
                        bot_lo_reg     <= fin_reg ? chain[COLUMNS].bot_lo : '0;
                        top_hi_reg     <= fin_reg ? chain[COLUMNS].top_hi : '0;
                        span_hi_reg    <= fin_reg ? chain[COLUMNS].span_hi : '0;
                        mask_reg       <= fin_reg ? MASK_W'(mask_vec) : '0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign is_summary       = is_summary_reg;
    assign placement_offset = offset_reg;
    assign placed_id        = pid_reg;
    assign peak_span        = peak_reg;
    assign bottom_at_left   = bot_lo_reg;
    assign top_at_right     = top_hi_reg;
    assign span_at_right    = span_hi_reg;
    assign bottleneck_mask  = mask_reg;

    // Checks
    `SIP_ASSERT_NEXT(a_apply_loads_out, apply_fire, out_valid_reg, "result not loaded on apply")
    `SIP_ASSERT_NEXT(a_finish_clears, apply_fire && fin_reg, touched_vec == '0, "store not cleared")
    `SIP_ASSERT_NOW(a_place_no_summary, out_valid_reg && !is_summary_reg, (mask_reg == '0) && (peak_reg == '0), "summary fields set in a placement result")

endmodule
